// File: rtl/msdtb_pkg.sv
// Shared types and constants for the multi-slot delay timer bank.
// Depends on nothing; every other file in rtl/ imports this package.
`default_nettype none

package msdtb_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int TICK_WIDTH = 32;

  // Slot index, walk pointer (must reach SLOT_COUNT) and armed-count widths.
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PTR_W  = $clog2(SLOT_COUNT + 1);
  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  // Number of slots that appear in the 16-bit flag field.
  localparam int FLAG_W = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef logic [TICK_WIDTH-1:0] tick_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [31:0] delay_ticks;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic [15:0] expired_flags;
    logic [4:0]  active_count;
    logic        ticking;
  } result_t;

  // Output of the shared decrement unit.
  typedef struct packed {
    logic  expire;
    tick_t value;
  } dec_res_t;

endpackage

`default_nettype wire

// File: rtl/msdtb_dec.sv
// Shared countdown unit: decrements one slot counter and flags expiry.
// Depends on msdtb_pkg for the counter type.
`default_nettype none

module msdtb_dec (
  input  msdtb_pkg::tick_t    value,
  output msdtb_pkg::dec_res_t res
);
  import msdtb_pkg::*;

  // A counter of one or zero runs out on this tick, so zero never wraps.
  always_comb begin
    res.expire = (value[TICK_WIDTH-1:1] == '0);
    res.value  = value - TICK_WIDTH'(1);
  end

endmodule

`default_nettype wire

// File: rtl/multi_slot_delay_timer_bank_unit.sv
// Top level of the multi-slot delay timer bank: command sequencer, counter memory
// and slot flags. Depends on msdtb_pkg and msdtb_dec.
`default_nettype none

// A command is transferred at a rising edge where start is high and busy is low.
// Each command produces exactly one result, shown on result for a single cycle with
// done high; the receiver cannot stall it, so it must capture the result that cycle.
// A set, clear or unused command goes straight to the report state. A tick walks all
// SLOT_COUNT counters through the one shared decrementer, one slot per cycle, with
// the registered memory read in front, before the report state. The result strobe
// appears in the cycle in which busy drops, so a new command can be transferred
// in that same cycle. Counters live in a single-port-write, single-port-read
// memory with a registered read; the armed and expired flags are flip-flops
// cleared by reset. A counter value is only used for a slot that is armed, and
// arming always loads it first, so the memory needs no clearing after reset.

module multi_slot_delay_timer_bank_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  msdtb_pkg::cmd_t     cmd,
  output logic                done,
  output msdtb_pkg::result_t  result
);
  import msdtb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_REPORT} state_t;

  state_t                  state;
  tick_t                   ticks_mem [SLOT_COUNT];
  tick_t                   rd_data;
  logic [PTR_W-1:0]        rd_ptr;
  logic [SLOT_W-1:0]       proc_slot;
  logic                    proc_vld;
  logic [SLOT_COUNT-1:0]   armed;
  logic [SLOT_COUNT-1:0]   expired;
  logic [CNT_W-1:0]        armed_total;
  logic                    status_q;

  dec_res_t                dec_res;
  logic                    accept;
  logic [SLOT_W-1:0]       cmd_slot;
  logic                    cmd_slot_ok;
  logic                    bank_full;
  logic                    set_ok;
  logic                    walk_upd;
  logic                    rd_en;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_waddr;
  tick_t                   mem_wdata;
  result_t                 result_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  // Slot numbers at or beyond the bank size are ignored by set and clear.
  assign cmd_slot    = SLOT_W'(cmd.slot);
  assign cmd_slot_ok = (32'(cmd.slot) < SLOT_COUNT);
  assign bank_full   = (32'(armed_total) >= SLOT_COUNT);

  // A set only loads a counter when it arms an idle slot.
  assign set_ok = accept && (cmd.op == OP_SET) && !bank_full && cmd_slot_ok &&
                  !armed[cmd_slot];

  // During the walk, the slot read in the previous cycle is updated now. Slots that
  // are not armed, or that expire, leave their counter alone.
  msdtb_dec u_dec (
    .value (rd_data),
    .res   (dec_res)
  );

  assign walk_upd = (state == ST_WALK) && proc_vld && armed[proc_slot] && !dec_res.expire;

  // Set and the walk never overlap, so they share the single write port.
  assign mem_we    = set_ok || walk_upd;
  assign mem_waddr = set_ok ? cmd_slot : proc_slot;
  assign mem_wdata = set_ok ? TICK_WIDTH'(cmd.delay_ticks) : dec_res.value;
  assign rd_en     = (state == ST_WALK) && (32'(rd_ptr) < SLOT_COUNT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ticks_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= ticks_mem[rd_ptr[SLOT_W-1:0]];
    end
  end

  // The result reflects the state after the command has completed.
  always_comb begin
    result_next               = '0;
    result_next.status        = status_q;
    for (int i = 0; i < FLAG_W; i++) begin
      result_next.expired_flags[i] = expired[i];
    end
    result_next.active_count  = (32'(armed_total) > 31) ? 5'd31 : 5'(armed_total);
    result_next.ticking       = (armed_total != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      proc_vld    <= 1'b0;
      armed       <= '0;
      expired     <= '0;
      armed_total <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            status_q <= 1'b0;
            state    <= ST_REPORT;
            unique case (cmd.op)
              OP_TICK: begin
                rd_ptr   <= '0;
                proc_vld <= 1'b0;
                state    <= ST_WALK;
              end
              OP_SET: begin
                if (bank_full) begin
                  status_q <= 1'b1;
                end else if (set_ok) begin
                  armed[cmd_slot]   <= 1'b1;
                  expired[cmd_slot] <= 1'b0;
                  armed_total       <= armed_total + CNT_W'(1);
                end
              end
              OP_CLEAR: begin
                if (cmd_slot_ok) begin
                  expired[cmd_slot] <= 1'b0;
                  if (armed[cmd_slot]) begin
                    armed[cmd_slot] <= 1'b0;
                    armed_total     <= armed_total - CNT_W'(1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_WALK: begin
          if (proc_vld && armed[proc_slot] && dec_res.expire) begin
            armed[proc_slot]   <= 1'b0;
            expired[proc_slot] <= 1'b1;
            armed_total        <= armed_total - CNT_W'(1);
          end
          if (32'(rd_ptr) < SLOT_COUNT) begin
            proc_slot <= rd_ptr[SLOT_W-1:0];
            proc_vld  <= 1'b1;
            rd_ptr    <= rd_ptr + PTR_W'(1);
          end else begin
            proc_vld <= 1'b0;
            state    <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          done   <= 1'b1;
          result <= result_next;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: bench/timer_bank_checker.sv
// Checker for the multi-slot delay timer bank: predicts every result from the
// accepted commands and compares it with what the block shows. Depends on msdtb_pkg.
module timer_bank_checker
  import msdtb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    done,
  input  result_t result,
  output int      mismatches,
  output int      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Private copy of the bank state.
  tick_t   remaining_ticks [SLOT_COUNT];
  logic    slot_armed      [SLOT_COUNT];
  logic    slot_expired    [SLOT_COUNT];
  int      armed_total;

  result_t pending_results [$];
  int      mismatch_total = 0;
  int      pending_count  = 0;

  assign mismatches  = mismatch_total;
  assign outstanding = pending_count;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $realtime, msg);
    mismatch_total++;
  endtask

  // Applies one command to the private bank and returns the state it leaves.
  function automatic result_t apply_timer_command(cmd_t c);
    result_t r;
    int      i;
    r = '0;
    case (c.op)
      OP_TICK: begin
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (slot_armed[i]) begin
            if (remaining_ticks[i] <= 1) begin
              remaining_ticks[i] = '0;
              slot_expired[i]    = 1'b1;
              slot_armed[i]      = 1'b0;
              if (armed_total > 0) armed_total--;
            end else begin
              remaining_ticks[i] = remaining_ticks[i] - 1'b1;
            end
          end
        end
      end
      OP_SET: begin
        if (armed_total >= SLOT_COUNT) begin
          r.status = 1'b1;
        end else if (int'(c.slot) < SLOT_COUNT && !slot_armed[c.slot]) begin
          slot_armed[c.slot]      = 1'b1;
          remaining_ticks[c.slot] = tick_t'(c.delay_ticks);
          slot_expired[c.slot]    = 1'b0;
          armed_total++;
        end
      end
      OP_CLEAR: begin
        if (int'(c.slot) < SLOT_COUNT) begin
          slot_expired[c.slot] = 1'b0;
          if (slot_armed[c.slot]) begin
            slot_armed[c.slot] = 1'b0;
            if (armed_total > 0) armed_total--;
          end
        end
      end
      default: ;
    endcase
    for (i = 0; i < SLOT_COUNT && i < 16; i++)
      r.expired_flags[i] = slot_expired[i];
    r.active_count = (armed_total > 31) ? 5'd31 : 5'(armed_total);
    r.ticking      = (armed_total != 0);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        remaining_ticks[i] = '0;
        slot_armed[i]      = 1'b0;
        slot_expired[i]    = 1'b0;
      end
      armed_total = 0;
      pending_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result strobe with no command outstanding");
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status)
            report_mismatch($sformatf("status got %0h expected %0h",
                                      result.status, want.status));
          if (result.expired_flags !== want.expired_flags)
            report_mismatch($sformatf("expired_flags got %04h expected %04h",
                                      result.expired_flags, want.expired_flags));
          if (result.active_count !== want.active_count)
            report_mismatch($sformatf("active_count got %0d expected %0d",
                                      result.active_count, want.active_count));
          if (result.ticking !== want.ticking)
            report_mismatch($sformatf("ticking got %0h expected %0h",
                                      result.ticking, want.ticking));
        end
      end
      if (start && !busy)
        pending_results.push_back(apply_timer_command(cmd));
    end
    pending_count = pending_results.size();
  end

endmodule

// File: bench/multi_slot_delay_timer_bank_unit_tb.sv
// Testbench top for the multi-slot delay timer bank: clock, reset, command stimulus
// and the verdict. Depends on msdtb_pkg, the block and timer_bank_checker.
module multi_slot_delay_timer_bank_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msdtb_pkg::*;

  // The fourth op code has no meaning in the block; it must leave the bank alone.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET = 900;
  // The tail after the last result is a comfortable multiple of the time for
  // which a tick keeps the block busy.
  localparam int         TAIL_CYCLES = 4 * (SLOT_COUNT + 2);

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;
  int      mismatches;
  int      outstanding;

  always #2 clk = ~clk;

  multi_slot_delay_timer_bank_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  timer_bank_checker bank_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic cmd_t make_command(logic [1:0] op, int slot, logic [31:0] delay);
    cmd_t c;
    c.op          = op;
    c.slot        = 4'(slot);
    c.delay_ticks = delay;
    return c;
  endfunction

  // Draws one command. The op mix is set per phase by the caller. Delays are
  // mostly short so that armed slots really run out under ticks, with some
  // medium ones that keep the bank filling up and a few full-width values.
  function automatic cmd_t random_command(int set_pct, int tick_pct);
    cmd_t c;
    int   roll;
    int   pick;
    roll = $urandom_range(0, 99);
    if (roll < set_pct)
      c.op = OP_SET;
    else if (roll < set_pct + tick_pct)
      c.op = OP_TICK;
    else if (roll < 97)
      c.op = OP_CLEAR;
    else
      c.op = OP_UNUSED;
    c.slot = 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 50)
      c.delay_ticks = $urandom_range(0, 6);
    else if (pick < 85)
      c.delay_ticks = $urandom_range(7, 40);
    else
      c.delay_ticks = $urandom();
    return c;
  endfunction

  // Presents a command at the falling edge and holds it until the block takes
  // it: the transfer happens at the first rising edge with busy low. Start is
  // left high, so a following call gives a back-to-back transfer.
  task automatic issue_command(cmd_t c);
    @(negedge clk);
    start = 1'b1;
    cmd   = c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Sender idles for a number of cycles; the command bus carries noise that the
  // block must ignore while start is low.
  task automatic pause_sender(int cycles);
    logic [63:0] noise;
    repeat (cycles) begin
      @(negedge clk);
      noise = {$urandom(), $urandom()};
      start = 1'b0;
      cmd   = noise[$bits(cmd_t)-1:0];
    end
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int phase;
    int burst_left;
    int set_pct;
    int tick_pct;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. A tick on an empty bank and the unused op code come first.
    issue_command(make_command(OP_TICK, 0, 32'd0));
    issue_command(make_command(OP_UNUSED, 15, 32'hFFFF_FFFF));
    // A zero delay must expire on the very next tick instead of wrapping.
    issue_command(make_command(OP_SET, 0, 32'd0));
    issue_command(make_command(OP_TICK, 9, 32'd0));
    // Clearing an idle slot only drops its expired flag.
    issue_command(make_command(OP_CLEAR, 0, 32'd0));
    // Fill slots 0 to 14 with a mix of delay extremes.
    for (int i = 0; i < 15; i++) begin
      case (i % 4)
        0:       issue_command(make_command(OP_SET, i, 32'hFFFF_FFFF));
        1:       issue_command(make_command(OP_SET, i, 32'd1));
        2:       issue_command(make_command(OP_SET, i, 32'd0));
        default: issue_command(make_command(OP_SET, i, 32'd3));
      endcase
    end
    // A set on an armed slot reports success but neither reloads nor counts.
    issue_command(make_command(OP_SET, 3, 32'hAAAA_5555));
    issue_command(make_command(OP_SET, 15, 32'h5555_AAAA));
    // Every slot is armed now, so this set is refused with the busy status.
    issue_command(make_command(OP_SET, 7, 32'd2));
    // Clear an armed slot, then the same slot again while it is idle.
    issue_command(make_command(OP_CLEAR, 15, 32'd0));
    issue_command(make_command(OP_CLEAR, 15, 32'hFFFF_FFFF));
    // Slots loaded with zero and one run out together on this tick.
    issue_command(make_command(OP_TICK, 0, 32'd0));
    wait_for_drain();

    // Random part. Phases rotate between filling the bank, draining it with
    // ticks and a balanced mix. Inside each phase the sender works in bursts
    // with random gaps, and some bursts follow each other with no gap at all,
    // so that new commands wait at the block throughout a tick walk.
    sent       = 0;
    phase      = 0;
    burst_left = 0;
    while (sent < ITEM_TARGET) begin
      case (phase % 3)
        0: begin
          set_pct  = 75;
          tick_pct = 12;
        end
        1: begin
          set_pct  = 20;
          tick_pct = 65;
        end
        default: begin
          set_pct  = 45;
          tick_pct = 35;
        end
      endcase
      repeat ($urandom_range(60, 140)) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 25));
          burst_left = $urandom_range(1, 30);
        end
        issue_command(random_command(set_pct, tick_pct));
        burst_left--;
        sent++;
      end
      // Every other phase the sender stops until the bank has answered everything.
      if (phase % 2 == 1)
        wait_for_drain();
      phase++;
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: the slowest correct run needs well under a tenth of this.
  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
rtl/msdtb_pkg.sv
rtl/msdtb_dec.sv
rtl/multi_slot_delay_timer_bank_unit.sv
bench/timer_bank_checker.sv
bench/multi_slot_delay_timer_bank_unit_tb.sv
